### hdl/pu_pkg.sv
// ---------------------------------------------------------------------------
// Permutation unranking package
// Shared widths, the stage control struct and the factorial table.
// ---------------------------------------------------------------------------
package pu_pkg;

    localparam int RANK_W      = 45;
    localparam int ELEM_W      = 5;
    localparam int LEN_W       = 5;
    localparam int FACT_W      = 64;
    localparam int CMP_W       = 68;
    localparam int TDATA_IN_W  = 48;
    localparam int TDATA_OUT_W = 8;

    typedef struct packed {
        logic valid;
        logic err;
    } stage_ctl_t;

    // n! for n up to 20; larger codes read as all ones.
    function automatic logic [FACT_W-1:0] fact_lookup(input logic [LEN_W-1:0] n);
        logic [FACT_W-1:0] f;
        unique case (n)
            5'd0:    f = 64'd1;
            5'd1:    f = 64'd1;
            5'd2:    f = 64'd2;
            5'd3:    f = 64'd6;
            5'd4:    f = 64'd24;
            5'd5:    f = 64'd120;
            5'd6:    f = 64'd720;
            5'd7:    f = 64'd5040;
            5'd8:    f = 64'd40320;
            5'd9:    f = 64'd362880;
            5'd10:   f = 64'd3628800;
            5'd11:   f = 64'd39916800;
            5'd12:   f = 64'd479001600;
            5'd13:   f = 64'd6227020800;
            5'd14:   f = 64'd87178291200;
            5'd15:   f = 64'd1307674368000;
            5'd16:   f = 64'd20922789888000;
            5'd17:   f = 64'd355687428096000;
            5'd18:   f = 64'd6402373705728000;
            5'd19:   f = 64'd121645100408832000;
            5'd20:   f = 64'd2432902008176640000;
            default: f = '1;
        endcase
        return f;
    endfunction

endpackage

### hdl/pu_divstage.sv
// ---------------------------------------------------------------------------
// Permutation unranking: quotient bit stage
// One restoring-division step: compares the remaining rank with a shifted
// factorial, subtracts on a hit and records one bit of one Lehmer digit.
// ---------------------------------------------------------------------------
module pu_divstage #(
    parameter int MAX_LEN = 16,
    parameter int QW      = 4,
    parameter int DIGIT   = 0,
    parameter int BITPOS  = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [pu_pkg::LEN_W-1:0]      len,
    input  pu_pkg::stage_ctl_t            in_ctl,
    input  logic [pu_pkg::RANK_W-1:0]     in_rank,
    input  logic [MAX_LEN*QW-1:0]         in_digits,
    output pu_pkg::stage_ctl_t            out_ctl,
    output logic [pu_pkg::RANK_W-1:0]     out_rank,
    output logic [MAX_LEN*QW-1:0]         out_digits
);
    import pu_pkg::*;

    localparam int DW = MAX_LEN * QW;
    localparam logic [LEN_W-1:0] DIG = LEN_W'(DIGIT);

    stage_ctl_t          ctl_reg;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [DW-1:0]       digits_reg, digits_next;
    logic                active;
    logic                hit;
    logic [FACT_W-1:0]   fact;
    logic [CMP_W-1:0]    step;
    logic [CMP_W-1:0]    rank_ext;

    // Positions at or beyond the configured length always take digit zero.
    assign active   = len > DIG;
    assign fact     = fact_lookup(len - DIG - LEN_W'(1));
    assign step     = {{(CMP_W-FACT_W){1'b0}}, fact} << BITPOS;
    assign rank_ext = {{(CMP_W-RANK_W){1'b0}}, in_rank};
    assign hit      = active && (rank_ext >= step);

    always_comb begin
        rank_next   = hit ? (in_rank - step[RANK_W-1:0]) : in_rank;
        digits_next = in_digits;
        digits_next[DIGIT*QW+BITPOS] = hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rank_reg   <= rank_next;
            digits_reg <= digits_next;
        end
    end

    assign out_ctl    = ctl_reg;
    assign out_rank   = rank_reg;
    assign out_digits = digits_reg;

endmodule

### hdl/pu_emit.sv
// ---------------------------------------------------------------------------
// Permutation unranking: element emitter
// Turns a Lehmer code into elements, one per cycle while the consumer is ready,
// by picking from a list of unused elements that closes up behind each pick.
// ---------------------------------------------------------------------------
module pu_emit #(
    parameter int MAX_LEN = 16,
    parameter int QW      = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [pu_pkg::LEN_W-1:0]        len,
    input  pu_pkg::stage_ctl_t              in_ctl,
    input  logic [MAX_LEN*QW-1:0]           in_digits,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pu_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import pu_pkg::*;

    logic                busy_reg, busy_next;
    logic                err_reg, err_next;
    logic [QW-1:0]       pos_reg, pos_next;
    logic [QW-1:0]       digits_reg [MAX_LEN];
    logic [QW-1:0]       digits_next [MAX_LEN];
    logic [ELEM_W-1:0]   list_reg [MAX_LEN];
    logic [ELEM_W-1:0]   list_next [MAX_LEN];
    logic [ELEM_W-1:0]   list_init [MAX_LEN];
    logic [ELEM_W-1:0]   list_shift [MAX_LEN];
    logic [QW-1:0]       loaded_digits [MAX_LEN];
    logic                m_tvalid_reg, m_tvalid_next;
    logic [ELEM_W-1:0]   elem_reg, elem_next;
    logic                last_reg, last_next;
    logic                user_reg, user_next;
    logic                out_free;
    logic                emit;
    logic                is_last;
    logic                load;
    logic [QW-1:0]       pick;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign pick     = digits_reg[pos_reg];
    assign is_last  = err_reg || (LEN_W'(pos_reg) == len - LEN_W'(1));
    // A new request may load in the cycle that the previous one sends its last element.
    assign in_ready = !busy_reg || (emit && is_last);
    assign load     = in_ctl.valid && in_ready;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_list
        assign list_init[j]     = ELEM_W'(j + 1);
        assign loaded_digits[j] = in_digits[j*QW +: QW];
        if (j + 1 < MAX_LEN) begin : g_mid
            assign list_shift[j] = (QW'(j) < pick) ? list_reg[j] : list_reg[j+1];
        end else begin : g_end
            assign list_shift[j] = (QW'(j) < pick) ? list_reg[j] : '0;
        end
    end

    always_comb begin
        busy_next     = busy_reg;
        err_next      = err_reg;
        pos_next      = pos_reg;
        digits_next   = digits_reg;
        list_next     = list_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        elem_next     = elem_reg;
        last_next     = last_reg;
        user_next     = user_reg;

        if (emit) begin
            m_tvalid_next = 1'b1;
            elem_next     = err_reg ? '0 : list_reg[pick];
            last_next     = is_last;
            user_next     = err_reg;
            pos_next      = pos_reg + QW'(1);
            list_next     = list_shift;
            if (is_last) begin
                busy_next = 1'b0;
            end
        end

        if (load) begin
            busy_next   = 1'b1;
            err_next    = in_ctl.err;
            pos_next    = '0;
            digits_next = loaded_digits;
            list_next   = list_init;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        pos_reg    <= pos_next;
        digits_reg <= digits_next;
        list_reg   <= list_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
        user_reg   <= user_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-ELEM_W){1'b0}}, elem_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

### hdl/permutation_unrank.sv
// ---------------------------------------------------------------------------
// Permutation unranking
// Lexicographic permutation of a given rank, one element per result.
// ---------------------------------------------------------------------------
// A request carries a zero-based rank; the block returns the permutation of
// 1..L with that rank, one element per result with tlast on the final one,
// where L is perm_length (0 reads as 1, values above MAX_LEN as MAX_LEN).
// A rank not below L! returns a single result with element 0, tlast and the
// error flag in tuser. The rank is first split into its Lehmer digits by a
// pipeline of compare-and-subtract stages, one quotient bit per stage, behind
// an entry register, so a request passes 1 + MAX_LEN * clog2(MAX_LEN)
// registers (65 at MAX_LEN = 16) before the emitter. The emitter then sends
// one element per cycle while the consumer is ready, and it takes the next
// request from the pipeline in the cycle that it sends the final element of
// the current one. The pipeline stalls only while its last stage holds a
// request that the emitter cannot yet take.
module permutation_unrank #(
    parameter int MAX_LEN = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pu_pkg::TDATA_IN_W-1:0]   s_tdata,   // [44:0] rank
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pu_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [4:0] element
    output logic                            m_tlast,   // last element
    output logic                            m_tuser,   // [0] rank_error
    input  logic                            cfg_wr_en,
    input  logic [pu_pkg::LEN_W-1:0]        cfg_wr_data
);
    import pu_pkg::*;

    localparam int QW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int NS = MAX_LEN * QW;
    localparam int DW = MAX_LEN * QW;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    logic [LEN_W-1:0]    perm_length_reg;
    logic [LEN_W-1:0]    len_eff;
    logic                advance;
    logic                emit_ready;
    logic [RANK_W-1:0]   rank_in;
    logic                rank_err;

    stage_ctl_t          ctl   [NS+1];
    logic [RANK_W-1:0]   rank  [NS+1];
    logic [DW-1:0]       digits[NS+1];

    stage_ctl_t          entry_ctl_reg;
    logic [RANK_W-1:0]   entry_rank_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_length_reg <= LEN_W'(1);
        end else if (cfg_wr_en) begin
            perm_length_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (perm_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (perm_length_reg > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = perm_length_reg;
        end
    end

    assign rank_in  = s_tdata[RANK_W-1:0];
    assign rank_err = {{(FACT_W-RANK_W){1'b0}}, rank_in} >= fact_lookup(len_eff);

    // The whole pipeline moves together; it waits only when its tail is held.
    assign advance  = !ctl[NS].valid || emit_ready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_ctl_reg <= '0;
        end else if (advance) begin
            entry_ctl_reg.valid <= s_tvalid;
            entry_ctl_reg.err   <= rank_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            entry_rank_reg <= rank_in;
        end
    end

    assign ctl[0]    = entry_ctl_reg;
    assign rank[0]   = entry_rank_reg;
    assign digits[0] = '0;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        pu_divstage #(
            .MAX_LEN (MAX_LEN),
            .QW      (QW),
            .DIGIT   (s / QW),
            .BITPOS  (QW - 1 - (s % QW))
        ) u_stage (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .len        (len_eff),
            .in_ctl     (ctl[s]),
            .in_rank    (rank[s]),
            .in_digits  (digits[s]),
            .out_ctl    (ctl[s+1]),
            .out_rank   (rank[s+1]),
            .out_digits (digits[s+1])
        );
    end

    pu_emit #(
        .MAX_LEN (MAX_LEN),
        .QW      (QW)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .len       (len_eff),
        .in_ctl    (ctl[NS]),
        .in_digits (digits[NS]),
        .in_ready  (emit_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

### hdl/pu_checker.sv
// ---------------------------------------------------------------------------
// Permutation unranking checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module pu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pu_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input logic                            m_tlast,
    input logic                            m_tuser
);
    import pu_pkg::*;

    // An error result is a single result carrying element zero.
    a_error_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[ELEM_W-1:0] == '0))
        else $error("rank error result without tlast or with a non-zero element");

    // Good elements are one-based.
    a_elem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[ELEM_W-1:0] != '0))
        else $error("zero element outside a rank error");

    // Within one permutation the elements follow without gaps.
    a_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a permutation");

    // A held result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind permutation_unrank pu_checker u_pu_checker (.*);

### dv/permutation_unrank_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unranking testbench
// Drives ranks at a range of permutation lengths, predicts every element and
// the error result, and compares each element that the block returns.
// ---------------------------------------------------------------------------
module permutation_unrank_tb;
    import pu_pkg::*;

    localparam int MAX_LEN      = 16;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 100;

    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_MOSTLY
    } ready_mode_t;

    typedef struct {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              rank_error;
    } perm_elem_t;

    class perm_scoreboard;
        perm_elem_t       elem_q[$];
        logic [63:0]      fact_tab[MAX_LEN+1];
        logic [LEN_W-1:0] length_reg;
        int               errors;

        function new();
            fact_tab[0] = 64'd1;
            for (int i = 1; i <= MAX_LEN; i++) fact_tab[i] = fact_tab[i-1] * i;
            length_reg = 1;
            errors     = 0;
        endfunction

        // A length of zero reads as one, anything above the maximum as the maximum.
        function int clamp_length(logic [LEN_W-1:0] raw);
            if (raw == 0) return 1;
            if (raw > MAX_LEN) return MAX_LEN;
            return int'(raw);
        endfunction

        function logic [63:0] fact_of_length(logic [LEN_W-1:0] raw);
            return fact_tab[clamp_length(raw)];
        endfunction

        function int pending();
            return elem_q.size();
        endfunction

        function void append_expected(perm_elem_t e);
            elem_q.insert(elem_q.size(), e);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task note_rank(logic [RANK_W-1:0] rank);
            int          n;
            int          pick;
            logic [63:0] rem;
            logic [63:0] f;
            logic [MAX_LEN-1:0] used;
            perm_elem_t  e;
            n = clamp_length(length_reg);
            if (rank >= fact_tab[n]) begin
                e.element    = '0;
                e.last       = 1'b1;
                e.rank_error = 1'b1;
                append_expected(e);
                return;
            end
            rem  = rank;
            used = '0;
            for (int i = 0; i < n; i++) begin
                f    = fact_tab[n-i-1];
                pick = 0;
                // Skip each free candidate whose block of permutations lies wholly below the rank.
                for (int j = 0; j < n; j++) begin
                    if (used[j]) continue;
                    if (rem >= f) begin
                        rem -= f;
                    end else begin
                        pick = j;
                        break;
                    end
                end
                used[pick]   = 1'b1;
                e.element    = ELEM_W'(pick + 1);
                e.last       = (i == n - 1);
                e.rank_error = 1'b0;
                append_expected(e);
            end
        endtask

        task check_result(logic [ELEM_W-1:0] element, logic last, logic rank_error);
            perm_elem_t e;
            if (elem_q.size() == 0) begin
                report($sformatf("unexpected result element=%0d last=%0b error=%0b",
                                 element, last, rank_error));
                return;
            end
            e = elem_q.pop_front();
            if (element !== e.element || last !== e.last || rank_error !== e.rank_error)
                report($sformatf("element=%0d/%0d last=%0b/%0b error=%0b/%0b (got/exp)",
                                 element, e.element, last, e.last, rank_error, e.rank_error));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_wr_en;
    logic [LEN_W-1:0]       cfg_wr_data;

    perm_scoreboard   sb;
    int               burst_left;
    bit               hold_off_req;
    logic [LEN_W-1:0] cur_len;

    permutation_unrank #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (cfg_wr_en) sb.length_reg = cfg_wr_data;
            if (s_tvalid && s_tready) sb.note_rank(s_tdata[RANK_W-1:0]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata[ELEM_W-1:0], m_tlast, m_tuser);
        end
    end

    // Result side: stall pattern of its own, plus one long hold-off on request.
    initial begin
        ready_mode_t mode;
        int          mode_left;
        m_tready  <= 1'b0;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(4, 60);
                end
                mode_left--;
                unique case (mode)
                    RDY_ALWAYS: m_tready <= 1'b1;
                    RDY_HALF:   m_tready <= ($urandom_range(0, 1) == 0);
                    RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    RDY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic logic [RANK_W-1:0] pick_rank(logic [63:0] f);
        logic [63:0] raw;
        int          kind;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(0, 99);
        if (kind < 65) return RANK_W'(raw % f);
        if (kind < 75) return RANK_W'(f - 1);
        if (kind < 80) return RANK_W'(f);
        if (kind < 85) return RANK_W'($urandom_range(0, 3));
        return raw[RANK_W-1:0];
    endfunction

    task automatic send_rank(input logic [RANK_W-1:0] rank);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_IN_W-RANK_W){1'b0}}, rank};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // The first edge lets the monitor finish with the last request before counting.
    task automatic wait_idle();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        s_tvalid <= 1'b0;
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        cur_len     = len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len, input int count, input bit hold);
        write_length(len);
        if (hold) hold_off_req = 1'b1;
        repeat (count) send_rank(pick_rank(sb.fact_of_length(cur_len)));
    endtask

    initial begin
        sb           = new();
        burst_left   = 0;
        hold_off_req = 1'b0;
        cur_len      = 1;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Length one straight out of reset: only rank zero is good.
        send_rank('0);
        send_rank(45'd1);
        send_rank('1);

        // Zero length reads as one.
        write_length(5'd0);
        send_rank('0);
        send_rank(45'd1);

        // Length far above the maximum reads as the maximum.
        write_length(5'd31);
        send_rank('0);
        send_rank(45'd1);
        send_rank(45'd20922789887999);
        send_rank(45'd20922789888000);
        send_rank(45'h0AAA_AAAA_AAAA);
        send_rank(45'h1555_5555_5555);
        send_rank('1);

        write_length(5'd2);
        send_rank('0);
        send_rank(45'd1);
        send_rank(45'd2);

        write_length(5'd3);
        send_rank(45'd5);
        send_rank(45'd6);

        // Long stall on the result side while requests keep coming.
        run_phase(5'd16, 100, 1'b1);
        run_phase(5'd4,  19, 1'b0);
        run_phase(5'd8,  19, 1'b0);
        run_phase(5'd1,  19, 1'b0);
        run_phase(5'd12, 19, 1'b0);
        run_phase(5'd5,  19, 1'b0);
        run_phase(5'd15, 19, 1'b0);
        run_phase(5'd3,  19, 1'b0);
        run_phase(5'd0,  19, 1'b0);
        run_phase(5'd17, 19, 1'b0);
        run_phase(5'd9,  19, 1'b0);
        run_phase(5'd2,  19, 1'b0);
        run_phase(5'd16, 19, 1'b0);
        run_phase(5'd13, 19, 1'b0);
        run_phase(5'd6,  19, 1'b0);
        run_phase(5'd31, 19, 1'b0);
        run_phase(5'd7,  19, 1'b0);

        s_tvalid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
